// ----- design/fcif_pkg.sv -----
// Shared types, constants and saturating arithmetic for the frozen-core fold block.
// No dependencies; imported by the top level.
`default_nettype none

package fcif_pkg;

    // Fixed field widths
    localparam int DATA_W      = 64;
    localparam int IDX_IN_W    = 3;
    localparam int MODE_W      = 2;
    localparam int CFG_DATA_W  = 4;
    localparam int CFG_INDEX_W = 1;

    // Stream widths: fields packed from bit 0 up, padded to whole bytes
    localparam int S_TDATA_W = 80;  // 4 indices + value = 76 bits
    localparam int S_TUSER_W = MODE_W;
    localparam int M_TDATA_W = 72;  // row + col + value = 70 bits
    localparam int M_TUSER_W = 1;

    localparam int ORBITALS_MAX_DEF = 8;

    // Register reset values
    localparam logic [CFG_DATA_W-1:0] ORBITAL_COUNT_RESET = 4'd8;
    localparam logic [CFG_DATA_W-1:0] FROZEN_COUNT_RESET  = 4'd0;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_ORBITAL_COUNT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_FROZEN_COUNT  = 1'b1;

    // Item kinds
    localparam logic [MODE_W-1:0] MODE_WRITE_H = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WRITE_G = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FOLD    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_ENERGY  = 2'd3;

    // Accumulator operations applied when read data returns
    typedef enum logic [2:0] {
        OP_LOAD,
        OP_ADD,
        OP_SUB,
        OP_SUBH,
        OP_ZERO
    } op_t;

    function automatic logic signed [DATA_W-1:0] sat_add(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        logic signed [DATA_W:0] s;
        s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        if (s[DATA_W] != s[DATA_W-1]) begin
            sat_add = s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            sat_add = s[DATA_W-1:0];
        end
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_sub(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        logic signed [DATA_W:0] s;
        s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
        if (s[DATA_W] != s[DATA_W-1]) begin
            sat_sub = s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            sat_sub = s[DATA_W-1:0];
        end
    endfunction

    // Arithmetic shift: rounds toward minus infinity
    function automatic logic signed [DATA_W-1:0] half(input logic signed [DATA_W-1:0] x);
        half = x >>> 1;
    endfunction

endpackage

`default_nettype wire

// ----- design/fcif_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module fcif_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- design/frozen_core_integral_fold_core.sv -----
// Frozen-core one-electron fold: top level with sequencer, accumulator and result register.
// Depends on fcif_pkg and fcif_ram.
`default_nettype none

// Write items (tuser = 0 for h, 1 for g) store one entry and produce no
// transfer on the result side. A fold item (tuser = 2) walks the active
// block of h row by row and, for each entry, issues one h read and then four g reads per
// frozen orbital, one read per cycle unless an entry's final read waits for the output
// register; (K-X)^2 results leave the block, the final one with tlast set. An energy item
// (tuser = 3) issues 3*X + 3*X*(X-1) reads (a single zeroing read when X = 0)
// and returns a single result with tuser set and tlast set. The rate of
// both compute items is set by the single read port of each memory. Each
// read returns in the next cycle into a saturating accumulator.
// A new item is taken as soon as the last read of the previous compute
// item has gone out; a finished result waits in the output register and
// stalls the sequencer only when the next result is ready to leave. Both
// memories come up undefined; every entry that a compute item touches
// must have been written first.
module frozen_core_integral_fold_core #(
    parameter int ORBITALS_MAX = fcif_pkg::ORBITALS_MAX_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    // Configuration write channel
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [fcif_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [fcif_pkg::CFG_DATA_W-1:0]   cfg_data,

    // Input items
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [2:0] idx_p, [5:3] idx_q, [8:6] idx_r, [11:9] idx_s, [75:12] entry_value
    input  wire logic [fcif_pkg::S_TDATA_W-1:0]    s_tdata,
    // [1:0] mode
    input  wire logic [fcif_pkg::S_TUSER_W-1:0]    s_tuser,

    // Result items
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [2:0] row, [5:3] col, [69:6] result_value
    output logic      [fcif_pkg::M_TDATA_W-1:0]    m_tdata,
    // [0] is_energy
    output logic      [fcif_pkg::M_TUSER_W-1:0]    m_tuser,
    output logic                                   m_tlast
);

    import fcif_pkg::*;

    // Index width inside the memories, count width for values up to ORBITALS_MAX
    localparam int IW   = (ORBITALS_MAX > 1) ? $clog2(ORBITALS_MAX) : 1;
    localparam int KW   = $clog2(ORBITALS_MAX + 1);
    localparam int H_AW = 2 * IW;
    localparam int G_AW = 4 * IW;
    localparam int H_DEPTH = 1 << H_AW;
    localparam int G_DEPTH = 1 << G_AW;
    localparam int PH_W = 4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FOLD,
        ST_ENERGY
    } state_t;

    // ------------------------------------------------------------------
    // Configuration registers: accept any value, clamp at use
    // ------------------------------------------------------------------
    logic [CFG_DATA_W-1:0] orbital_count_reg;
    logic [CFG_DATA_W-1:0] frozen_count_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            orbital_count_reg <= ORBITAL_COUNT_RESET;
            frozen_count_reg  <= FROZEN_COUNT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_ORBITAL_COUNT: orbital_count_reg <= cfg_data;
                REG_FROZEN_COUNT:  frozen_count_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Effective orbital count K and frozen count X
    logic [KW-1:0] k_eff;
    logic [KW-1:0] x_eff;

    always_comb begin
        if (orbital_count_reg == '0) begin
            k_eff = KW'(1);
        end else if (int'(orbital_count_reg) > ORBITALS_MAX) begin
            k_eff = KW'(ORBITALS_MAX);
        end else begin
            k_eff = KW'(orbital_count_reg);
        end
        if (int'(frozen_count_reg) > int'(k_eff)) begin
            x_eff = k_eff;
        end else begin
            x_eff = KW'(frozen_count_reg);
        end
    end

    // ------------------------------------------------------------------
    // Input unpacking
    // ------------------------------------------------------------------
    logic [MODE_W-1:0]   in_mode;
    logic [IDX_IN_W-1:0] in_p, in_q, in_r, in_s;
    logic [DATA_W-1:0]   in_value;
    logic                s_fire;

    assign in_mode  = s_tuser[MODE_W-1:0];
    assign in_p     = s_tdata[2:0];
    assign in_q     = s_tdata[5:3];
    assign in_r     = s_tdata[8:6];
    assign in_s     = s_tdata[11:9];
    assign in_value = s_tdata[75:12];
    assign s_fire   = s_tvalid && s_tready;

    // Drop writes with an index beyond the stores
    logic pq_ok, rs_ok;
    assign pq_ok = (int'(in_p) < ORBITALS_MAX) && (int'(in_q) < ORBITALS_MAX);
    assign rs_ok = (int'(in_r) < ORBITALS_MAX) && (int'(in_s) < ORBITALS_MAX);

    logic              h_we, g_we;
    logic [H_AW-1:0]   h_waddr;
    logic [G_AW-1:0]   g_waddr;

    assign h_we    = s_fire && (in_mode == MODE_WRITE_H) && pq_ok;
    assign g_we    = s_fire && (in_mode == MODE_WRITE_G) && pq_ok && rs_ok;
    assign h_waddr = {IW'(in_p), IW'(in_q)};
    assign g_waddr = {IW'(in_p), IW'(in_q), IW'(in_r), IW'(in_s)};

    // ------------------------------------------------------------------
    // Sequencer: unless a final read stalls, one memory read issued per cycle
    // ------------------------------------------------------------------
    state_t          state_reg, state_next;
    logic [KW-1:0]   k_reg, k_next;
    logic [KW-1:0]   x_reg, x_next;
    logic [KW-1:0]   a_reg, a_next;   // fold row, energy outer index
    logic [KW-1:0]   b_reg, b_next;   // fold column, energy inner index
    logic [KW-1:0]   l_reg, l_next;   // fold frozen orbital
    logic [PH_W-1:0] ph_reg, ph_next;
    logic            head_reg, head_next;

    logic            issue_req;
    logic            issue_final;
    logic            issue_fire;
    logic            issue_sel_g;
    op_t             issue_op;
    logic            issue_last;
    logic            issue_energy;
    logic [H_AW-1:0] h_raddr;
    logic [G_AW-1:0] g_raddr;
    logic            out_free;

    // Stage 1: read data returns
    logic            s1_valid_reg;
    logic            s1_final_reg;
    logic            s1_sel_g_reg;
    op_t             s1_op_reg;
    logic            s1_last_reg;
    logic            s1_energy_reg;
    logic [2:0]      s1_row_reg;
    logic [2:0]      s1_col_reg;

    // Output register
    logic            m_valid_reg;

    // A final read may go out only when its result will find the output register free
    assign out_free   = (!m_valid_reg || m_tready) && !(s1_valid_reg && s1_final_reg);
    assign issue_fire = issue_req && (!issue_final || out_free);
    assign s_tready   = (state_reg == ST_IDLE);

    logic [IW-1:0] ai, bi, li;
    logic          fold_entry_end;
    logic          fold_row_end, fold_col_end;

    assign ai = a_reg[IW-1:0];
    assign bi = b_reg[IW-1:0];
    assign li = l_reg[IW-1:0];
    assign fold_col_end = (KW'(b_reg + 1'b1) == k_reg);
    assign fold_row_end = (KW'(a_reg + 1'b1) == k_reg);
    assign fold_entry_end = head_reg ? (x_reg == '0)
                                     : ((ph_reg == PH_W'(3)) && (KW'(l_reg + 1'b1) == x_reg));

    always_comb begin
        state_next   = state_reg;
        k_next       = k_reg;
        x_next       = x_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        l_next       = l_reg;
        ph_next      = ph_reg;
        head_next    = head_reg;
        issue_req    = 1'b0;
        issue_final  = 1'b0;
        issue_sel_g  = 1'b0;
        issue_op     = OP_ADD;
        issue_last   = 1'b0;
        issue_energy = 1'b0;
        h_raddr      = {ai, bi};
        g_raddr      = {ai, bi, li, li};

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    k_next    = k_eff;
                    x_next    = x_eff;
                    a_next    = x_eff;
                    b_next    = x_eff;
                    l_next    = '0;
                    ph_next   = '0;
                    head_next = 1'b1;
                    if (in_mode == MODE_FOLD) begin
                        // No active orbitals: nothing to emit
                        if (x_eff != k_eff) begin
                            state_next = ST_FOLD;
                        end
                    end else if (in_mode == MODE_ENERGY) begin
                        a_next     = '0;
                        b_next     = '0;
                        state_next = ST_ENERGY;
                    end
                end
            end

            ST_FOLD: begin
                issue_req   = 1'b1;
                issue_final = fold_entry_end;
                issue_last  = fold_row_end && fold_col_end;
                if (head_reg) begin
                    issue_op = OP_LOAD;
                end else begin
                    issue_sel_g = 1'b1;
                    unique case (ph_reg[1:0])
                        2'd0: begin
                            g_raddr  = {ai, bi, li, li};
                            issue_op = OP_ADD;
                        end
                        2'd1: begin
                            g_raddr  = {li, li, ai, bi};
                            issue_op = OP_ADD;
                        end
                        2'd2: begin
                            g_raddr  = {ai, li, li, bi};
                            issue_op = OP_SUBH;
                        end
                        default: begin
                            g_raddr  = {li, bi, ai, li};
                            issue_op = OP_SUBH;
                        end
                    endcase
                end
                if (issue_fire) begin
                    if (fold_entry_end) begin
                        // Advance to the next active entry, row-major
                        head_next = 1'b1;
                        l_next    = '0;
                        ph_next   = '0;
                        if (fold_col_end) begin
                            b_next = x_reg;
                            if (fold_row_end) begin
                                state_next = ST_IDLE;
                            end else begin
                                a_next = KW'(a_reg + 1'b1);
                            end
                        end else begin
                            b_next = KW'(b_reg + 1'b1);
                        end
                    end else if (head_reg) begin
                        head_next = 1'b0;
                    end else if (ph_reg == PH_W'(3)) begin
                        ph_next = '0;
                        l_next  = KW'(l_reg + 1'b1);
                    end else begin
                        ph_next = PH_W'(ph_reg + 1'b1);
                    end
                end
            end

            ST_ENERGY: begin
                issue_req    = 1'b1;
                issue_energy = 1'b1;
                issue_last   = 1'b1;
                if (x_reg == '0) begin
                    // No frozen orbitals: energy is zero
                    issue_op    = OP_ZERO;
                    issue_final = 1'b1;
                    if (issue_fire) begin
                        state_next = ST_IDLE;
                    end
                end else begin
                    // a = i, b = j
                    issue_sel_g = 1'b1;
                    unique case (ph_reg)
                        PH_W'(0): begin
                            issue_sel_g = 1'b0;
                            h_raddr     = {ai, ai};
                            issue_op    = (a_reg == '0) ? OP_LOAD : OP_ADD;
                        end
                        PH_W'(1): begin
                            issue_sel_g = 1'b0;
                            h_raddr     = {ai, ai};
                        end
                        PH_W'(2): g_raddr = {ai, ai, ai, ai};
                        PH_W'(3), PH_W'(4): g_raddr = {ai, ai, bi, bi};
                        PH_W'(5), PH_W'(6): g_raddr = {bi, bi, ai, ai};
                        PH_W'(7): begin
                            g_raddr  = {bi, ai, ai, bi};
                            issue_op = OP_SUB;
                        end
                        default: begin
                            g_raddr  = {ai, bi, bi, ai};
                            issue_op = OP_SUB;
                        end
                    endcase
                    issue_final = (ph_reg == PH_W'(2)) && (KW'(a_reg + 1'b1) == x_reg);
                    if (issue_fire) begin
                        if (ph_reg == PH_W'(2)) begin
                            if (KW'(a_reg + 1'b1) == x_reg) begin
                                state_next = ST_IDLE;
                            end else begin
                                b_next  = KW'(a_reg + 1'b1);
                                ph_next = PH_W'(3);
                            end
                        end else if (ph_reg >= PH_W'(8)) begin
                            if (KW'(b_reg + 1'b1) == x_reg) begin
                                a_next  = KW'(a_reg + 1'b1);
                                ph_next = '0;
                            end else begin
                                b_next  = KW'(b_reg + 1'b1);
                                ph_next = PH_W'(3);
                            end
                        end else begin
                            ph_next = PH_W'(ph_reg + 1'b1);
                        end
                    end
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            x_reg     <= '0;
            a_reg     <= '0;
            b_reg     <= '0;
            l_reg     <= '0;
            ph_reg    <= '0;
            head_reg  <= 1'b1;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
            x_reg     <= x_next;
            a_reg     <= a_next;
            b_reg     <= b_next;
            l_reg     <= l_next;
            ph_reg    <= ph_next;
            head_reg  <= head_next;
        end
    end

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] h_rdata, g_rdata;

    fcif_ram #(
        .WIDTH (DATA_W),
        .DEPTH (H_DEPTH)
    ) u_h_ram (
        .aclk  (aclk),
        .we    (h_we),
        .waddr (h_waddr),
        .wdata (in_value),
        .re    (issue_fire && !issue_sel_g),
        .raddr (h_raddr),
        .rdata (h_rdata)
    );

    fcif_ram #(
        .WIDTH (DATA_W),
        .DEPTH (G_DEPTH)
    ) u_g_ram (
        .aclk  (aclk),
        .we    (g_we),
        .waddr (g_waddr),
        .wdata (in_value),
        .re    (issue_fire && issue_sel_g),
        .raddr (g_raddr),
        .rdata (g_rdata)
    );

    // ------------------------------------------------------------------
    // Stage 1: tag that travels with each read
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s1_final_reg <= 1'b0;
        end else begin
            s1_valid_reg <= issue_fire;
            s1_final_reg <= issue_fire && issue_final;
        end
        s1_sel_g_reg  <= issue_sel_g;
        s1_op_reg     <= issue_op;
        s1_last_reg   <= issue_last;
        s1_energy_reg <= issue_energy;
        s1_row_reg    <= issue_energy ? 3'd0 : 3'(a_reg - x_reg);
        s1_col_reg    <= issue_energy ? 3'd0 : 3'(b_reg - x_reg);
    end

    // ------------------------------------------------------------------
    // Saturating accumulator
    // ------------------------------------------------------------------
    logic signed [DATA_W-1:0] acc_reg, acc_next;
    logic signed [DATA_W-1:0] operand;

    assign operand = s1_sel_g_reg ? g_rdata : h_rdata;

    always_comb begin
        unique case (s1_op_reg)
            OP_LOAD: acc_next = operand;
            OP_ADD:  acc_next = sat_add(acc_reg, operand);
            OP_SUB:  acc_next = sat_sub(acc_reg, operand);
            OP_SUBH: acc_next = sat_sub(acc_reg, half(operand));
            OP_ZERO: acc_next = '0;
            default: acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            acc_reg <= acc_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register: load on a final read, clear on transfer
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] out_value_reg;
    logic [2:0]        out_row_reg, out_col_reg;
    logic              out_energy_reg, out_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_valid_reg && s1_final_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (s1_valid_reg && s1_final_reg) begin
            out_value_reg  <= acc_next;
            out_row_reg    <= s1_row_reg;
            out_col_reg    <= s1_col_reg;
            out_energy_reg <= s1_energy_reg;
            out_last_reg   <= s1_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, out_value_reg, out_col_reg, out_row_reg};
    assign m_tuser  = out_energy_reg;
    assign m_tlast  = out_last_reg;

`ifndef SYNTH
    // A final result never lands on an occupied output register
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && s1_final_reg) |-> !(m_valid_reg && !m_tready))
        else $error("result overwrote a pending output");

    // Fold indices stay below K, and the column index stays inside the active block
    a_fold_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FOLD) |-> (a_reg < k_reg) && (b_reg < k_reg) && (b_reg >= x_reg))
        else $error("fold index out of range");

    // Frozen orbital counter stays below X while g reads are issued
    a_frozen_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FOLD && !head_reg) |-> (l_reg < x_reg))
        else $error("frozen index out of range");

    // Energy results are single and always close the run
    a_energy_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_energy_reg) |-> out_last_reg)
        else $error("energy result without last");

    // No new item is taken while reads are still being issued
    a_idle_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        issue_req |-> !s_tready)
        else $error("input accepted during a compute walk");
`endif

endmodule

`default_nettype wire
